### sv/tdc_pkg.sv
// ----------------------------------------------------------------------------
// tdc_pkg: shared constants and helpers for the tick delta converter
// Field widths, request and unit codes, scaling constants.
// ----------------------------------------------------------------------------
package tdc_pkg;

  localparam int REQ_W      = 2;
  localparam int CNT_W      = 64;   // width of the counter reading field
  localparam int UNIT_W     = 2;
  localparam int UNITS_W    = 64;   // width of the result field
  localparam int RATE_W     = 32;
  localparam int FACTOR_W   = 30;   // holds 10^9 and the unit divisors
  localparam int PROD_W     = RATE_W + FACTOR_W;
  localparam int DIVISOR_W  = 52;   // (2^32-1) * 10^6 < 2^52
  localparam int DIVIDEND_W = 96;   // elapsed * 10^9 + leftover < 2^95
  localparam int LEFT_W     = 53;   // stored leftover width
  localparam int PADDR_W    = 3;
  localparam int PDATA_W    = 32;

  localparam int COUNTER_BITS_DEF = 64;

  localparam logic [RATE_W-1:0] RATE_RESET = 32'd1000;

  // request codes
  localparam logic [REQ_W-1:0] REQ_RESTART = 2'd0;
  localparam logic [REQ_W-1:0] REQ_MEASURE = 2'd1;
  localparam logic [REQ_W-1:0] REQ_PEEK    = 2'd2;
  localparam logic [REQ_W-1:0] REQ_INIT    = 2'd3;

  // unit codes
  localparam logic [UNIT_W-1:0] UNIT_MS = 2'd0;
  localparam logic [UNIT_W-1:0] UNIT_US = 2'd1;
  localparam logic [UNIT_W-1:0] UNIT_NS = 2'd2;

  localparam logic [FACTOR_W-1:0] NS_PER_SEC = 30'd1000000000;

  // register index of tick_rate
  localparam logic [0:0] REG_TICK_RATE = 1'b0;

  function automatic logic [FACTOR_W-1:0] unit_factor(input logic [UNIT_W-1:0] sel);
    logic [FACTOR_W-1:0] f;
    case (sel)
      UNIT_MS: f = 30'd1000000;
      UNIT_US: f = 30'd1000;
      default: f = 30'd1;        // nanoseconds, unknown code too
    endcase
    return f;
  endfunction

endpackage

### sv/tdc_if.sv
// ----------------------------------------------------------------------------
// tdc_in_if / tdc_out_if: valid-ready channels of the tick delta converter
// Request channel and result channel with source and sink modports.
// ----------------------------------------------------------------------------
interface tdc_in_if;
  import tdc_pkg::*;

  logic              valid;
  logic              ready;
  logic [REQ_W-1:0]  req_type;
  logic [CNT_W-1:0]  counter_reading;
  logic [UNIT_W-1:0] unit_select;

  modport source (output valid, output req_type, output counter_reading,
                  output unit_select, input ready);
  modport sink   (input valid, input req_type, input counter_reading,
                  input unit_select, output ready);
endinterface

interface tdc_out_if;
  import tdc_pkg::*;

  logic               valid;
  logic               ready;
  logic [UNITS_W-1:0] elapsed_units;
  logic               saturated;

  modport source (output valid, output elapsed_units, output saturated, input ready);
  modport sink   (input valid, input elapsed_units, input saturated, output ready);
endinterface

### sv/tdc_cfg_regs.sv
// ----------------------------------------------------------------------------
// tdc_cfg_regs: APB register file
// Holds tick_rate; zero-wait writes and reads.
// ----------------------------------------------------------------------------
module tdc_cfg_regs (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [tdc_pkg::PADDR_W-1:0]  paddr,
  input  logic [tdc_pkg::PDATA_W-1:0]  pwdata,
  output logic [tdc_pkg::PDATA_W-1:0]  prdata,
  output logic                         pready,
  output logic [tdc_pkg::RATE_W-1:0]   tick_rate
);
  import tdc_pkg::*;

  logic [RATE_W-1:0] rate_r;
  logic              hit;

  assign pready    = 1'b1;
  assign hit       = (paddr[PADDR_W-1:2] == REG_TICK_RATE);
  assign prdata    = hit ? rate_r : '0;
  assign tick_rate = rate_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rate_r <= RATE_RESET;
    end else if (psel && penable && pwrite && pready && hit) begin
      rate_r <= pwdata;
    end
  end

endmodule

### sv/tdc_div_unit.sv
// ----------------------------------------------------------------------------
// tdc_div_unit: bit-serial restoring divider
// One quotient bit per cycle; quotient shifts into the dividend register.
// ----------------------------------------------------------------------------
module tdc_div_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [tdc_pkg::DIVIDEND_W-1:0] dividend,
  input  logic [tdc_pkg::DIVISOR_W-1:0]  divisor,
  output logic                           done,
  output logic [tdc_pkg::DIVIDEND_W-1:0] quotient,
  output logic [tdc_pkg::DIVISOR_W-1:0]  remainder
);
  import tdc_pkg::*;

  localparam int STEP_W = $clog2(DIVIDEND_W);

  logic                  busy_r, busy_nxt;
  logic [STEP_W-1:0]     step_r, step_nxt;
  logic [DIVIDEND_W-1:0] dvd_r, dvd_nxt;
  logic [DIVISOR_W-1:0]  rem_r, rem_nxt;
  logic [DIVISOR_W-1:0]  dsr_r;
  logic [DIVISOR_W:0]    rem_sh;
  logic                  qbit;
  logic                  last;

  assign rem_sh = {rem_r, dvd_r[DIVIDEND_W-1]};
  assign qbit   = (rem_sh >= {1'b0, dsr_r});
  assign last   = busy_r && (step_r == STEP_W'(DIVIDEND_W - 1));

  always_comb begin
    busy_nxt = busy_r;
    step_nxt = step_r;
    dvd_nxt  = dvd_r;
    rem_nxt  = rem_r;
    if (start) begin
      busy_nxt = 1'b1;
      step_nxt = '0;
      dvd_nxt  = dividend;
      rem_nxt  = '0;
    end else if (busy_r) begin
      dvd_nxt  = {dvd_r[DIVIDEND_W-2:0], qbit};
      rem_nxt  = qbit ? DIVISOR_W'(rem_sh - {1'b0, dsr_r}) : rem_sh[DIVISOR_W-1:0];
      step_nxt = step_r + 1'b1;
      if (last) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      step_r <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
    if (start) dsr_r <= divisor;
  end

  // remainder is < divisor, so the top bit of rem_sh is dropped safely
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done <= 1'b0;
    end else begin
      done <= last;
    end
  end

  assign quotient  = dvd_r;
  assign remainder = rem_r;

endmodule

### sv/tick_delta_time_unit_converter_unit.sv
// ----------------------------------------------------------------------------
// tick_delta_time_unit_converter_unit: elapsed tick to time unit converter
// Converts counter deltas to ms/us/ns with an exact carried remainder.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  : request transfer (req_type, counter_reading, unit_select).
//   out_ch : one result transfer per request (elapsed_units, saturated).
//   cfg_*  : APB port, tick_rate at byte address 0 (ticks per second).
// Sequence:
//   restart / init : straight to the result state, then the output register.
//   measure / peek : three passes through a shared 32x30 multiplier (divisor,
//     low and high halves of ticks*10^9), then a 96-step bit-serial divide,
//     one quotient bit per cycle.
// Throughput: one request at a time; in_ch.ready is high only while the
//   sequencer is idle. A finished result sits in the output register, so the
//   next request can be taken while the receiver still holds it off.
// Stall: if out_ch.ready stays low, the next result waits in the sequencer
//   until the output register frees up; nothing is dropped.
// Reset: rst_n (synchronous) clears reference and leftover, tick_rate=1000.
// ----------------------------------------------------------------------------
module tick_delta_time_unit_converter_unit #(
  parameter int COUNTER_BITS = tdc_pkg::COUNTER_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  tdc_in_if.sink                       in_ch,
  tdc_out_if.source                    out_ch,
  input  logic                         cfg_psel,
  input  logic                         cfg_penable,
  input  logic                         cfg_pwrite,
  input  logic [tdc_pkg::PADDR_W-1:0]  cfg_paddr,
  input  logic [tdc_pkg::PDATA_W-1:0]  cfg_pwdata,
  output logic [tdc_pkg::PDATA_W-1:0]  cfg_prdata,
  output logic                         cfg_pready
);
  import tdc_pkg::*;

  // sequencer states
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_MUL_DV = 3'd1;  // divisor = rate * unit factor
  localparam logic [2:0] S_MUL_LO = 3'd2;  // acc = lo32 * 10^9 + leftover
  localparam logic [2:0] S_MUL_HI = 3'd3;  // acc += (hi32 * 10^9) << 32
  localparam logic [2:0] S_LAUNCH = 3'd4;  // kick the divider
  localparam logic [2:0] S_DIV    = 3'd5;
  localparam logic [2:0] S_RESULT = 3'd6;  // wait for the output register

  logic [2:0] state_r, state_nxt;

  logic [RATE_W-1:0]       tick_rate;
  logic [RATE_W-1:0]       rate_eff;
  logic [COUNTER_BITS-1:0] ref_r;
  logic [LEFT_W-1:0]       left_r;
  logic [CNT_W-1:0]        elapsed_r;
  logic [UNIT_W-1:0]       unit_r;
  logic                    measure_r;
  logic [DIVISOR_W-1:0]    divisor_r;
  logic [DIVIDEND_W-1:0]   acc_r;
  logic [UNITS_W-1:0]      res_units_r;
  logic                    res_sat_r;
  logic                    out_valid_r;
  logic [UNITS_W-1:0]      out_units_r;
  logic                    out_sat_r;

  logic                    in_fire;
  logic                    out_free;
  logic [COUNTER_BITS-1:0] reading;
  logic [COUNTER_BITS-1:0] delta;

  // shared multiplier
  logic [RATE_W-1:0]   mul_a;
  logic [FACTOR_W-1:0] mul_b;
  logic [PROD_W-1:0]   mul_p;

  logic                  div_start;
  logic                  div_done;
  logic [DIVIDEND_W-1:0] div_quot;
  logic [DIVISOR_W-1:0]  div_rem;

  tdc_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .psel      (cfg_psel),
    .penable   (cfg_penable),
    .pwrite    (cfg_pwrite),
    .paddr     (cfg_paddr),
    .pwdata    (cfg_pwdata),
    .prdata    (cfg_prdata),
    .pready    (cfg_pready),
    .tick_rate (tick_rate)
  );

  tdc_div_unit u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (acc_r),
    .divisor   (divisor_r),
    .done      (div_done),
    .quotient  (div_quot),
    .remainder (div_rem)
  );

  // a zero rate counts as one tick per second
  assign rate_eff = (tick_rate == '0) ? RATE_W'(1) : tick_rate;

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid_r || out_ch.ready;
  assign div_start   = (state_r == S_LAUNCH);

  // counter wraps modulo 2^COUNTER_BITS
  assign reading = in_ch.counter_reading[COUNTER_BITS-1:0];
  assign delta   = reading - ref_r;

  always_comb begin
    mul_a = elapsed_r[RATE_W-1:0];
    mul_b = NS_PER_SEC;
    unique case (state_r)
      S_MUL_DV: begin
        mul_a = rate_eff;
        mul_b = unit_factor(unit_r);
      end
      S_MUL_HI: mul_a = elapsed_r[CNT_W-1:RATE_W];
      default:  mul_a = elapsed_r[RATE_W-1:0];
    endcase
  end

  assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          if (in_ch.req_type == REQ_MEASURE || in_ch.req_type == REQ_PEEK) begin
            state_nxt = S_MUL_DV;
          end else begin
            state_nxt = S_RESULT;
          end
        end
      end
      S_MUL_DV: state_nxt = S_MUL_LO;
      S_MUL_LO: state_nxt = S_MUL_HI;
      S_MUL_HI: state_nxt = S_LAUNCH;
      S_LAUNCH: state_nxt = S_DIV;
      S_DIV:    if (div_done) state_nxt = S_RESULT;
      S_RESULT: if (out_free) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  // control and architectural state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ref_r       <= '0;
      left_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;

      // restart, init and measure all re-arm the reference at the transfer
      if (in_fire && in_ch.req_type != REQ_PEEK) ref_r <= reading;
      if (in_fire && in_ch.req_type == REQ_INIT) left_r <= '0;

      // only a measure consumes the remainder
      if (state_r == S_DIV && div_done && measure_r) begin
        left_r <= LEFT_W'(div_rem);
      end

      if (state_r == S_RESULT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (in_fire) begin
      elapsed_r   <= CNT_W'(delta);
      unit_r      <= in_ch.unit_select;
      measure_r   <= (in_ch.req_type == REQ_MEASURE);
      res_units_r <= '0;   // restart and init report zero
      res_sat_r   <= 1'b0;
    end

    unique case (state_r)
      S_MUL_DV: divisor_r <= DIVISOR_W'(mul_p);
      S_MUL_LO: acc_r <= DIVIDEND_W'(mul_p) + DIVIDEND_W'(left_r);
      S_MUL_HI: acc_r <= acc_r + DIVIDEND_W'({mul_p, RATE_W'(0)});
      default: ;
    endcase

    // quotient bits above 63 mean the count does not fit: clamp
    if (state_r == S_DIV && div_done) begin
      res_sat_r   <= |div_quot[DIVIDEND_W-1:UNITS_W];
      res_units_r <= (|div_quot[DIVIDEND_W-1:UNITS_W]) ? '1 : div_quot[UNITS_W-1:0];
    end

    if (state_r == S_RESULT && out_free) begin
      out_units_r <= res_units_r;
      out_sat_r   <= res_sat_r;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.elapsed_units = out_units_r;
  assign out_ch.saturated     = out_sat_r;

endmodule

### dv/tdc_checker.sv
// ----------------------------------------------------------------------------
// tdc_checker: result predictor and comparator for the tick delta converter
// Watches the request, result and APB channels, keeps its own copy of the
// tick rate, reference reading and carried tick-nanoseconds, and checks every
// result transfer against the oldest prediction. Also checks register reads.
// ----------------------------------------------------------------------------
module tdc_checker (
  input  logic                        clk,
  input  logic                        rst_n,
  tdc_in_if                           in_mon,
  tdc_out_if                          out_mon,
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [tdc_pkg::PADDR_W-1:0] cfg_paddr,
  input  logic [tdc_pkg::PDATA_W-1:0] cfg_pwdata,
  input  logic [tdc_pkg::PDATA_W-1:0] cfg_prdata,
  input  logic                        cfg_pready,
  output int                          fail_count,
  output int                          units_awaited,
  output int                          results_seen,
  output int                          saturations
);
  timeunit 1ns;
  timeprecision 1ps;
  import tdc_pkg::*;

  typedef struct packed {
    logic [UNITS_W-1:0] units;
    logic               sat;
  } elapsed_t;

  localparam logic [CNT_W-1:0]   CNT_MASK  = {CNT_W{1'b1}} >> (CNT_W - COUNTER_BITS_DEF);
  localparam logic [PADDR_W-1:0] RATE_ADDR = {REG_TICK_RATE, 2'b00};

  logic [RATE_W-1:0] tick_rate;
  logic [CNT_W-1:0]  ref_count;
  logic [LEFT_W-1:0] carry_tns;
  elapsed_t          awaited_units[$];

  // exact (ticks * 1e9 + carry) / (rate * unit scale); updates state as the
  // block does for the given request
  function automatic elapsed_t ticks_to_units(input logic [REQ_W-1:0]  req,
                                              input logic [CNT_W-1:0]  reading,
                                              input logic [UNIT_W-1:0] unit);
    logic [127:0]     dividend;
    logic [127:0]     divisor;
    logic [127:0]     quot;
    logic [127:0]     rem;
    logic [CNT_W-1:0] ticks;
    elapsed_t         res;
    res = '0;
    if (req == REQ_RESTART || req == REQ_INIT) begin
      ref_count = reading & CNT_MASK;
      if (req == REQ_INIT) carry_tns = '0;
      return res;
    end
    ticks    = (reading - ref_count) & CNT_MASK;
    dividend = ticks;
    dividend = dividend * NS_PER_SEC + carry_tns;
    divisor  = tick_rate;
    if (tick_rate == '0) divisor = 1;      // zero rate behaves as one
    case (unit)
      UNIT_MS: divisor = divisor * 1000000;
      UNIT_US: divisor = divisor * 1000;
      default: ;                            // ns, and the unused code
    endcase
    quot      = dividend / divisor;
    rem       = dividend % divisor;
    res.sat   = |quot[127:UNITS_W];
    res.units = res.sat ? {UNITS_W{1'b1}} : quot[UNITS_W-1:0];
    if (req == REQ_MEASURE) begin
      ref_count = reading & CNT_MASK;
      carry_tns = rem[LEFT_W-1:0];
    end
    return res;
  endfunction

  task automatic report(input string what, input logic [63:0] want, input logic [63:0] got);
    fail_count++;
    $display("%0t: %s mismatch, expected %0d (0x%h), got %0d (0x%h)",
             $time, what, want, want, got, got);
  endtask

  always @(posedge clk) begin : watch
    elapsed_t want;
    if (!rst_n) begin
      tick_rate = RATE_RESET;
      ref_count = '0;
      carry_tns = '0;
      awaited_units.delete();
    end else begin
      if (cfg_psel && cfg_penable && cfg_pready && cfg_paddr == RATE_ADDR) begin
        if (cfg_pwrite) tick_rate = cfg_pwdata;
        else if (cfg_prdata !== tick_rate) report("tick_rate readback", tick_rate, cfg_prdata);
      end
      if (in_mon.valid && in_mon.ready)
        awaited_units.push_back(ticks_to_units(in_mon.req_type, in_mon.counter_reading,
                                               in_mon.unit_select));
      if (out_mon.valid && out_mon.ready) begin
        if (awaited_units.size() == 0) begin
          fail_count++;
          $display("%0t: result transfer with nothing expected, expected none, got %0d sat %0b",
                   $time, out_mon.elapsed_units, out_mon.saturated);
        end else begin
          want = awaited_units.pop_front();
          results_seen++;
          if (want.sat) saturations++;
          if (out_mon.elapsed_units !== want.units)
            report("elapsed_units", want.units, out_mon.elapsed_units);
          if (out_mon.saturated !== want.sat)
            report("saturated", 64'(want.sat), 64'(out_mon.saturated));
        end
      end
    end
    units_awaited = awaited_units.size();
  end

endmodule

### dv/tb.sv
// ----------------------------------------------------------------------------
// tb: top-level testbench for the tick delta time unit converter
// Drives request transfers and APB tick rate writes, throttles the result
// channel, and leaves prediction and comparison to tdc_checker. Runs a short
// directed pass, then six random passes at different tick rates and idling
// patterns, and reports the verdict.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import tdc_pkg::*;

  localparam int LIMIT_CYCLES = 1000000;
  localparam int CHUNK_ITEMS  = 180;
  localparam int N_CHUNKS     = 6;
  localparam int TAIL_CYCLES  = 150;      // longer than one measure request takes

  // unit code the block maps onto nanoseconds
  localparam logic [UNIT_W-1:0]  UNIT_UNUSED = 2'd3;
  localparam logic [PADDR_W-1:0] RATE_ADDR   = {REG_TICK_RATE, 2'b00};

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic               cfg_psel;
  logic               cfg_penable;
  logic               cfg_pwrite;
  logic [PADDR_W-1:0] cfg_paddr;
  logic [PDATA_W-1:0] cfg_pwdata;
  logic [PDATA_W-1:0] cfg_prdata;
  logic               cfg_pready;

  tdc_in_if  in_ch ();
  tdc_out_if out_ch ();

  // idling, in percent of cycles, for each side
  int in_idle_pct;
  int out_idle_pct;

  int fail_count;
  int units_awaited;
  int results_seen;
  int saturations;
  int cycle_count;
  int sent_by_req [4];
  int rate_settings;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  tick_delta_time_unit_converter_unit dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  tdc_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_mon        (in_ch),
    .out_mon       (out_ch),
    .cfg_psel      (cfg_psel),
    .cfg_penable   (cfg_penable),
    .cfg_pwrite    (cfg_pwrite),
    .cfg_paddr     (cfg_paddr),
    .cfg_pwdata    (cfg_pwdata),
    .cfg_prdata    (cfg_prdata),
    .cfg_pready    (cfg_pready),
    .fail_count    (fail_count),
    .units_awaited (units_awaited),
    .results_seen  (results_seen),
    .saturations   (saturations)
  );

  // result-side throttle: one decision per falling edge
  always @(negedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= out_idle_pct);
  end

  // One request transfer. Valid is left high after acceptance; the next call
  // either keeps it up or drops it at the following falling edge, so there is
  // never more than one assignment to valid per time step.
  task automatic send_req(input logic [REQ_W-1:0]  req,
                          input logic [CNT_W-1:0]  reading,
                          input logic [UNIT_W-1:0] unit);
    @(negedge clk);
    while ($urandom_range(99) < in_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid           <= 1'b1;
    in_ch.req_type        <= req;
    in_ch.counter_reading <= reading;
    in_ch.unit_select     <= unit;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sent_by_req[req]++;
  endtask

  // Stop sending and wait until every predicted result has been transferred.
  task automatic drain();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (units_awaited != 0) @(negedge clk);
  endtask

  // APB transfer: setup cycle, then access cycle until pready.
  task automatic cfg_access(input logic write, input logic [PDATA_W-1:0] value);
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= write;
    cfg_paddr   <= RATE_ADDR;
    cfg_pwdata  <= value;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    if (write) rate_settings++;
  endtask

  // runaway guard
  initial begin
    cycle_count = 0;
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("%0t: no completion within %0d cycles", $time, LIMIT_CYCLES);
    $display("simulation failed");
    $finish;
  end

  initial begin : stimulus
    logic [RATE_W-1:0] chunk_rate [N_CHUNKS];
    logic [RATE_W-1:0] rate;
    logic [CNT_W-1:0]  reading;
    logic [CNT_W-1:0]  last_reading;
    logic [REQ_W-1:0]  req;
    logic [UNIT_W-1:0] unit;
    int                pick;

    // rate extremes, a crystal-like rate, zero (treated as one), a random
    // draw and a fast timer rate
    chunk_rate = '{32'd1, 32'hFFFF_FFFF, 32'd32768, 32'd0, 32'd0, 32'd19200000};

    in_ch.valid           = 1'b0;
    in_ch.req_type        = REQ_RESTART;
    in_ch.counter_reading = '0;
    in_ch.unit_select     = UNIT_MS;
    out_ch.ready          = 1'b0;
    cfg_psel              = 1'b0;
    cfg_penable           = 1'b0;
    cfg_pwrite            = 1'b0;
    cfg_paddr             = '0;
    cfg_pwdata            = '0;
    in_idle_pct           = 35;
    out_idle_pct          = 85;
    rate_settings         = 1;    // the reset rate counts as one setting

    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    // --- directed pass at the reset rate of 1000 ticks/s -------------------
    cfg_access(1'b0, '0);                              // reset value readback
    send_req(REQ_MEASURE, 64'd0, UNIT_MS);             // nothing elapsed
    send_req(REQ_RESTART, 64'd100, UNIT_NS);
    send_req(REQ_PEEK, 64'd1100, UNIT_US);             // one second, state kept
    send_req(REQ_MEASURE, 64'd1100, UNIT_MS);
    send_req(REQ_MEASURE, 64'd1101, UNIT_UNUSED);      // unused unit -> ns
    send_req(REQ_INIT, {CNT_W{1'b1}}, UNIT_MS);        // reference at all ones
    send_req(REQ_MEASURE, 64'd4, UNIT_US);             // counter wrap
    send_req(REQ_PEEK, 64'h8000_0000_0000_0004, UNIT_NS);    // saturates
    send_req(REQ_MEASURE, 64'h8000_0000_0000_0004, UNIT_NS); // saturates, stores

    // rate of 3 leaves a remainder; mix units to exercise the carry
    drain();
    cfg_access(1'b1, 32'd3);
    cfg_access(1'b0, '0);
    send_req(REQ_INIT, 64'd0, UNIT_MS);
    send_req(REQ_MEASURE, 64'd1, UNIT_MS);
    send_req(REQ_MEASURE, 64'd1, UNIT_US);             // carry only
    send_req(REQ_PEEK, 64'd2, UNIT_NS);
    send_req(REQ_RESTART, 64'd5, UNIT_MS);             // carry survives restart
    send_req(REQ_MEASURE, 64'd6, UNIT_MS);
    send_req(REQ_INIT, 64'd6, UNIT_NS);                // carry cleared

    drain();
    cfg_access(1'b1, 32'd0);                           // zero rate
    send_req(REQ_MEASURE, 64'd7, UNIT_NS);
    send_req(REQ_MEASURE, 64'h0000_0000_FFFF_FFFF, UNIT_MS);

    drain();
    cfg_access(1'b1, 32'hFFFF_FFFF);                   // top rate
    send_req(REQ_MEASURE, 64'hFFFF_FFFF_FFFF_FFFE, UNIT_MS);
    send_req(REQ_PEEK, 64'h5555_5555_5555_5555, UNIT_MS);
    send_req(REQ_MEASURE, 64'hAAAA_AAAA_AAAA_AAAA, UNIT_UNUSED);

    // --- random passes ------------------------------------------------------
    last_reading = 64'hAAAA_AAAA_AAAA_AAAA;
    for (int c = 0; c < N_CHUNKS; c++) begin
      drain();
      // idling: sender light / receiver heavy, then swapped, then none
      case (c / 2)
        0: begin in_idle_pct = 35; out_idle_pct = 85; end
        1: begin in_idle_pct = 85; out_idle_pct = 35; end
        default: begin in_idle_pct = 0; out_idle_pct = 0; end
      endcase
      rate = (c == 4) ? $urandom : chunk_rate[c];
      cfg_access(1'b1, rate);
      cfg_access(1'b0, '0);

      for (int i = 0; i < CHUNK_ITEMS; i++) begin
        pick = $urandom_range(99);
        if (pick < 12)      req = REQ_RESTART;
        else if (pick < 60) req = REQ_MEASURE;
        else if (pick < 85) req = REQ_PEEK;
        else                req = REQ_INIT;

        unit = ($urandom_range(15) == 0) ? UNIT_UNUSED : UNIT_W'($urandom_range(2));

        // mostly forward steps of a running counter, some far jumps and
        // backward steps that look like a near-full wrap
        case ($urandom_range(9))
          0, 1, 2, 3: reading = last_reading + $urandom_range(5000);
          4, 5:       reading = last_reading + {32'd0, $urandom};
          6:          reading = last_reading + ({$urandom, $urandom} >> $urandom_range(63));
          7:          reading = {$urandom, $urandom};
          8:          reading = last_reading - $urandom_range(3);
          default:    reading = {CNT_W{1'b1}} - $urandom_range(50);
        endcase
        last_reading = reading;
        send_req(req, reading, unit);
      end
    end

    // --- wrap-up ------------------------------------------------------------
    drain();
    in_idle_pct  = 0;
    out_idle_pct = 0;
    repeat (TAIL_CYCLES) @(negedge clk);

    $display("requests: %0d restart, %0d measure, %0d peek, %0d init over %0d tick rates",
             sent_by_req[REQ_RESTART], sent_by_req[REQ_MEASURE], sent_by_req[REQ_PEEK],
             sent_by_req[REQ_INIT], rate_settings);
    $display("results compared: %0d, %0d of them clamped, in %0d cycles",
             results_seen, saturations, cycle_count);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

### sim.f
sv/tdc_pkg.sv
sv/tdc_if.sv
sv/tdc_cfg_regs.sv
sv/tdc_div_unit.sv
sv/tick_delta_time_unit_converter_unit.sv
dv/tdc_checker.sv
dv/tb.sv
